FILE: rtl/quintic_trajectory_generator_core_assert.svh
// Assertion macros shared by the trajectory generator RTL.
`ifndef QUINTIC_TRAJECTORY_GENERATOR_CORE_ASSERT_SVH
`define QUINTIC_TRAJECTORY_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define QTG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qtg: same-cycle check failed");
// Antecedent implies consequent in the next cycle.
`define QTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qtg: next-cycle check failed");
`else
`define QTG_ASSERT_NOW(label, ante, cons)
`define QTG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/qtg_pkg.sv
package qtg_pkg;

    // Fixed geometry of the generator.
    localparam int AXES      = 3;
    localparam int POS_W     = 32;
    localparam int AX_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int MS_W      = 16;

    // Shared arithmetic units.
    localparam int DIV_W  = 46;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Duration limits and reset value in milliseconds.
    localparam logic [MS_W-1:0] MIN_MS    = 16'd50;
    localparam logic [MS_W-1:0] MAX_MS    = 16'd60000;
    localparam logic [MS_W-1:0] DUR_RESET = 16'd1000;

    // Request codes.
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_START_ABS = 2'd1;
    localparam logic [1:0] REQ_START_REL = 2'd2;
    localparam logic [1:0] REQ_CLEAR     = 2'd3;

endpackage

FILE: rtl/qtg_div.sv
// Restoring divider: one quotient bit per cycle.
module qtg_div import qtg_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [MS_W-1:0]  divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [MS_W-1:0]  rem_reg, rem_next;
    logic [MS_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [MS_W:0]    rem_shift;
    logic [MS_W:0]    rem_diff;
    logic             fits;

    // One trial subtraction per cycle.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? rem_diff[MS_W-1:0] : rem_shift[MS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/quintic_trajectory_generator_core.sv
// Three-axis minimum-jerk trajectory generator with one shared multiplier and divider.
// Start, clear and idle ticks go to ST_OUT, which loads the result once the output is free.
// A tick during a move runs a 46-step division for u, six polynomial multiply steps, the
// per-axis steps with a 46-step velocity division for each axis, and one output load.
// One request at a time; a new request is taken while the last result still waits.
// Synchronous active-low reset: limits open, trajectory zero, duration 1000 ms.
`include "quintic_trajectory_generator_core_assert.svh"
module quintic_trajectory_generator_core import qtg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [POS_W-1:0]     s_axis1_target,
    input  logic [POS_W-1:0]     s_axis2_target,
    input  logic [POS_W-1:0]     s_axis3_target,
    input  logic [POS_W-1:0]     s_axis1_current,
    input  logic [POS_W-1:0]     s_axis2_current,
    input  logic [POS_W-1:0]     s_axis3_current,
    input  logic [MS_W-1:0]      s_move_time_ms,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [POS_W-1:0]     m_axis1_ref,
    output logic [POS_W-1:0]     m_axis2_ref,
    output logic [POS_W-1:0]     m_axis3_ref,
    output logic [POS_W-1:0]     m_axis1_vel,
    output logic [POS_W-1:0]     m_axis2_vel,
    output logic [POS_W-1:0]     m_axis3_vel,
    output logic                 m_has_reference,
    output logic                 m_moving,
    output logic                 m_finished
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIVU = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_M3   = 4'd4;
    localparam logic [3:0] ST_M4   = 4'd5;
    localparam logic [3:0] ST_M5   = 4'd6;
    localparam logic [3:0] ST_M6   = 4'd7;
    localparam logic [3:0] ST_A1   = 4'd8;
    localparam logic [3:0] ST_A2   = 4'd9;
    localparam logic [3:0] ST_A3   = 4'd10;
    localparam logic [3:0] ST_A4   = 4'd11;
    localparam logic [3:0] ST_A5   = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << 29;
    localparam logic [30:0]       Q30_ONE  = 31'h4000_0000;
    localparam logic [POS_W-1:0]  VEL_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]  VEL_MIN  = {1'b1, {(POS_W-1){1'b0}}};

    logic [3:0]        state_reg, state_next;
    logic [AX_W-1:0]   axis_reg, axis_next;
    logic [POS_W-1:0]  lim_min_reg [AXES];
    logic [POS_W-1:0]  lim_max_reg [AXES];
    logic [POS_W-1:0]  start_reg [AXES], start_next [AXES];
    logic [POS_W-1:0]  goal_reg  [AXES], goal_next  [AXES];
    logic [POS_W-1:0]  ref_reg   [AXES], ref_next   [AXES];
    logic [POS_W-1:0]  vel_reg   [AXES], vel_next   [AXES];
    logic [MS_W-1:0]   elapsed_reg, elapsed_next;
    logic [MS_W-1:0]   dur_reg, dur_next;
    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic              has_ref_reg, has_ref_next;
    logic [29:0]       u_reg, u_next;
    logic [29:0]       u2_reg, u2_next;
    logic [30:0]       w2_reg, w2_next;
    logic [29:0]       u3_reg, u3_next;
    logic [30:0]       s_reg, s_next;
    logic [30:0]       dsdu_reg, dsdu_next;
    logic [32:0]       vr_reg, vr_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  m_ref_reg [AXES], m_ref_next [AXES];
    logic [POS_W-1:0]  m_vel_reg [AXES], m_vel_next [AXES];
    logic [2:0]        m_flags_reg, m_flags_next;

    logic [POS_W-1:0]  tgt_in [AXES];
    logic [POS_W-1:0]  cur_in [AXES];
    logic [POS_W-1:0]  goal_clamp [AXES];
    logic [MS_W-1:0]   dur_clamp;
    logic [MS_W-1:0]   elapsed_inc;
    logic [30:0]       w_val;
    logic [34:0]       inner;
    logic [PROD_W-1:0] prod_x30;
    logic [PROD_W-1:0] prod_rnd;
    logic signed [32:0] delta;
    logic              delta_neg;
    logic [32:0]       mag;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [POS_W-1:0]  vel_sat;

    assign tgt_in[0] = s_axis1_target;
    assign tgt_in[1] = s_axis2_target;
    assign tgt_in[2] = s_axis3_target;
    assign cur_in[0] = s_axis1_current;
    assign cur_in[1] = s_axis2_current;
    assign cur_in[2] = s_axis3_current;

    // Goal: absolute or start plus delta at full width, raised to min, then lowered to max.
    always_comb begin
        logic signed [POS_W:0] g;
        for (int i = 0; i < AXES; i++) begin
            if (s_req_type == REQ_START_REL) begin
                g = $signed({cur_in[i][POS_W-1], cur_in[i]})
                    + $signed({tgt_in[i][POS_W-1], tgt_in[i]});
            end else begin
                g = $signed({tgt_in[i][POS_W-1], tgt_in[i]});
            end
            if (g < $signed({lim_min_reg[i][POS_W-1], lim_min_reg[i]})) begin
                g = $signed({lim_min_reg[i][POS_W-1], lim_min_reg[i]});
            end
            if (g > $signed({lim_max_reg[i][POS_W-1], lim_max_reg[i]})) begin
                g = $signed({lim_max_reg[i][POS_W-1], lim_max_reg[i]});
            end
            goal_clamp[i] = g[POS_W-1:0];
        end
    end

    // Duration clamp.
    always_comb begin
        if (s_move_time_ms < MIN_MS) begin
            dur_clamp = MIN_MS;
        end else if (s_move_time_ms > MAX_MS) begin
            dur_clamp = MAX_MS;
        end else begin
            dur_clamp = s_move_time_ms;
        end
    end

    // Polynomial helper terms and the selected axis's displacement.
    always_comb begin
        elapsed_inc = elapsed_reg + 1'b1;
        w_val       = Q30_ONE - {1'b0, u_reg};
        inner       = (35'd10 << 30) + 35'(u2_reg) * 35'd6 - 35'(u_reg) * 35'd15;
        prod_x30    = (prod_reg << 5) - (prod_reg << 1);
        prod_rnd    = prod_reg + RND_HALF;
        delta       = $signed({goal_reg[axis_reg][POS_W-1], goal_reg[axis_reg]})
                      - $signed({start_reg[axis_reg][POS_W-1], start_reg[axis_reg]});
        delta_neg   = delta[32];
        mag         = delta_neg ? 33'(-delta) : 33'(delta);
    end

    // Velocity saturation from the unsigned quotient.
    always_comb begin
        if (delta_neg) begin
            vel_sat = (div_quo >= DIV_W'(64'h8000_0000)) ? VEL_MIN : -div_quo[POS_W-1:0];
        end else begin
            vel_sat = (div_quo > DIV_W'(64'h7FFF_FFFF)) ? VEL_MAX : div_quo[POS_W-1:0];
        end
    end

    // Operand select for the shared multiplier.
    always_comb begin
        case (state_reg)
            ST_M1: begin
                mul_a = MUL_W'(u_reg);
                mul_b = MUL_W'(u_reg);
            end
            ST_M2: begin
                mul_a = MUL_W'(w_val);
                mul_b = MUL_W'(w_val);
            end
            ST_M3: begin
                mul_a = MUL_W'(u2_reg);
                mul_b = MUL_W'(u_reg);
            end
            ST_M4: begin
                mul_a = MUL_W'(u2_reg);
                mul_b = MUL_W'(w2_reg);
            end
            ST_M5: begin
                mul_a = MUL_W'(u3_reg);
                mul_b = inner[MUL_W-1:0];
            end
            ST_A1: begin
                mul_a = MUL_W'(mag);
                mul_b = MUL_W'(s_reg);
            end
            ST_A2: begin
                mul_a = MUL_W'(mag);
                mul_b = MUL_W'(dsdu_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared divider.
    qtg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer and datapath next state.
    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        start_next   = start_reg;
        goal_next    = goal_reg;
        ref_next     = ref_reg;
        vel_next     = vel_reg;
        elapsed_next = elapsed_reg;
        dur_next     = dur_reg;
        active_next  = active_reg;
        done_next    = done_reg;
        has_ref_next = has_ref_reg;
        u_next       = u_reg;
        u2_next      = u2_reg;
        w2_next      = w2_reg;
        u3_next      = u3_reg;
        s_next       = s_reg;
        dsdu_next    = dsdu_reg;
        vr_next      = vr_reg;
        prod_next    = prod_reg;
        div_start    = 1'b0;
        div_dividend = {elapsed_inc, 30'b0};
        m_valid_next = m_valid_reg && !m_ready;
        m_ref_next   = m_ref_reg;
        m_vel_next   = m_vel_reg;
        m_flags_next = m_flags_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_OUT;
                    case (s_req_type)
                        REQ_START_ABS, REQ_START_REL: begin
                            for (int i = 0; i < AXES; i++) begin
                                start_next[i] = cur_in[i];
                                goal_next[i]  = goal_clamp[i];
                                ref_next[i]   = cur_in[i];
                                vel_next[i]   = '0;
                            end
                            dur_next     = dur_clamp;
                            elapsed_next = '0;
                            active_next  = 1'b1;
                            done_next    = 1'b0;
                            has_ref_next = 1'b1;
                        end
                        REQ_CLEAR: begin
                            for (int i = 0; i < AXES; i++) begin
                                start_next[i] = '0;
                                goal_next[i]  = '0;
                                ref_next[i]   = '0;
                                vel_next[i]   = '0;
                            end
                            elapsed_next = '0;
                            active_next  = 1'b0;
                            done_next    = 1'b0;
                            has_ref_next = 1'b0;
                        end
                        default: begin
                            if (has_ref_reg) begin
                                if (active_reg && (elapsed_inc < dur_reg)) begin
                                    elapsed_next = elapsed_inc;
                                    div_start    = 1'b1;
                                    state_next   = ST_DIVU;
                                end else begin
                                    if (active_reg) begin
                                        elapsed_next = elapsed_inc;
                                        active_next  = 1'b0;
                                        done_next    = 1'b1;
                                    end
                                    for (int i = 0; i < AXES; i++) begin
                                        ref_next[i] = goal_reg[i];
                                        vel_next[i] = '0;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DIVU: begin
                if (div_done) begin
                    u_next     = div_quo[29:0];
                    state_next = ST_M1;
                end
            end
            ST_M1: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_M2;
            end
            ST_M2: begin
                u2_next    = prod_reg[59:30];
                prod_next  = mul_a * mul_b;
                state_next = ST_M3;
            end
            ST_M3: begin
                w2_next    = prod_reg[60:30];
                prod_next  = mul_a * mul_b;
                state_next = ST_M4;
            end
            ST_M4: begin
                u3_next    = prod_reg[59:30];
                prod_next  = mul_a * mul_b;
                state_next = ST_M5;
            end
            ST_M5: begin
                dsdu_next  = prod_x30[60:30];
                prod_next  = mul_a * mul_b;
                state_next = ST_M6;
            end
            ST_M6: begin
                s_next     = prod_reg[60:30];
                axis_next  = '0;
                state_next = ST_A1;
            end
            ST_A1: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_A2;
            end
            ST_A2: begin
                if (delta_neg) begin
                    ref_next[axis_reg] = start_reg[axis_reg] - prod_rnd[61:30];
                end else begin
                    ref_next[axis_reg] = start_reg[axis_reg] + prod_rnd[61:30];
                end
                prod_next  = mul_a * mul_b;
                state_next = ST_A3;
            end
            ST_A3: begin
                vr_next    = prod_rnd[62:30];
                state_next = ST_A4;
            end
            ST_A4: begin
                // Scale to units per second with rounding: (vr * 1000 + dur / 2) / dur.
                div_dividend = (DIV_W'(vr_reg) << 10) - (DIV_W'(vr_reg) << 4)
                               - (DIV_W'(vr_reg) << 3) + DIV_W'(dur_reg >> 1);
                div_start    = 1'b1;
                state_next   = ST_A5;
            end
            ST_A5: begin
                if (div_done) begin
                    vel_next[axis_reg] = vel_sat;
                    if (axis_reg == AX_W'(AXES - 1)) begin
                        state_next = ST_OUT;
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_A1;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ref_next   = ref_reg;
                    m_vel_next   = vel_reg;
                    m_flags_next = {done_reg, active_reg, has_ref_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and trajectory state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            elapsed_reg <= '0;
            dur_reg     <= DUR_RESET;
            active_reg  <= 1'b0;
            done_reg    <= 1'b0;
            has_ref_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                start_reg[i] <= '0;
                goal_reg[i]  <= '0;
                ref_reg[i]   <= '0;
                vel_reg[i]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            elapsed_reg <= elapsed_next;
            dur_reg     <= dur_next;
            active_reg  <= active_next;
            done_reg    <= done_next;
            has_ref_reg <= has_ref_next;
            start_reg   <= start_next;
            goal_reg    <= goal_next;
            ref_reg     <= ref_next;
            vel_reg     <= vel_next;
        end
        axis_reg    <= axis_next;
        u_reg       <= u_next;
        u2_reg      <= u2_next;
        w2_reg      <= w2_next;
        u3_reg      <= u3_next;
        s_reg       <= s_next;
        dsdu_reg    <= dsdu_next;
        vr_reg      <= vr_next;
        prod_reg    <= prod_next;
        m_ref_reg   <= m_ref_next;
        m_vel_reg   <= m_vel_next;
        m_flags_reg <= m_flags_next;
    end

    // Goal limit registers; indexes past the last axis are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                lim_min_reg[i] <= VEL_MIN;
                lim_max_reg[i] <= VEL_MAX;
            end
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(2 * AXES))) begin
            if (cfg_index[0]) begin
                lim_max_reg[cfg_index[AX_W:1]] <= cfg_data;
            end else begin
                lim_min_reg[cfg_index[AX_W:1]] <= cfg_data;
            end
        end
    end

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_axis1_ref     = m_ref_reg[0];
    assign m_axis2_ref     = m_ref_reg[1];
    assign m_axis3_ref     = m_ref_reg[2];
    assign m_axis1_vel     = m_vel_reg[0];
    assign m_axis2_vel     = m_vel_reg[1];
    assign m_axis3_vel     = m_vel_reg[2];
    assign m_has_reference = m_flags_reg[0];
    assign m_moving        = m_flags_reg[1];
    assign m_finished      = m_flags_reg[2];

    // A move in progress never also reports finished, and always has a reference.
    `QTG_ASSERT_NOW(a_active_not_done, active_reg, !done_reg)
    `QTG_ASSERT_NOW(a_active_has_ref, active_reg, has_ref_reg)
    // Only one request is in work at a time.
    `QTG_ASSERT_NEXT(a_one_request, s_valid && s_ready, !s_ready)
    // A pending result is only replaced once it has been taken.
    `QTG_ASSERT_NEXT(a_out_hold, m_valid && !m_ready && state_reg != ST_OUT, m_valid)

endmodule

FILE: dv/tb.sv
module tb;
    import qtg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 20000;

    typedef struct {
        logic [1:0]       req;
        logic [POS_W-1:0] tgt [AXES];
        logic [POS_W-1:0] cur [AXES];
        logic [MS_W-1:0]  ms;
    } traj_req_t;

    typedef struct {
        logic [POS_W-1:0] refp [AXES];
        logic [POS_W-1:0] vel [AXES];
        logic             has_ref;
        logic             moving;
        logic             finished;
    } traj_out_t;

    // Trajectory predictor plus the queue of outputs it expects.
    class traj_scoreboard;
        longint           lim_lo [AXES];
        longint           lim_hi [AXES];
        longint           start_p [AXES];
        longint           goal_p [AXES];
        longint           ref_p [AXES];
        longint           ref_v [AXES];
        int unsigned      elapsed;
        int unsigned      dur;
        bit               active;
        bit               done;
        bit               has_ref;
        traj_out_t        pending_q [$];
        int               errors;
        int               checked;

        function new();
            for (int i = 0; i < AXES; i++) begin
                lim_lo[i] = -64'sd2147483648;
                lim_hi[i] = 64'sd2147483647;
            end
            zero_motion();
            dur = 1000;
            errors = 0;
            checked = 0;
        endfunction

        function void zero_motion();
            for (int i = 0; i < AXES; i++) begin
                start_p[i] = 0;
                goal_p[i] = 0;
                ref_p[i] = 0;
                ref_v[i] = 0;
            end
            elapsed = 0;
            active = 0;
            done = 0;
            has_ref = 0;
        endfunction

        function void hold_goal();
            for (int i = 0; i < AXES; i++) begin
                ref_p[i] = goal_p[i];
                ref_v[i] = 0;
            end
        endfunction

        // Rounded (mag * f) / 2^30 without overflowing 64 bits.
        function longint unsigned scale_q30(longint unsigned mag, longint unsigned f);
            longint unsigned hi_part;
            longint unsigned lo_part;
            hi_part = mag >> 30;
            lo_part = mag & 64'h3FFF_FFFF;
            return hi_part * f + ((lo_part * f + 64'h2000_0000) >> 30);
        endfunction

        // Quintic position and velocity at the current elapsed time.
        function void eval_quintic();
            longint unsigned u, u2, u3, w, w2, inner, s, dsdu, mag, dp, v;
            longint d;
            longint vs;
            u = (longint'(elapsed) << 30) / dur;
            u2 = (u * u) >> 30;
            u3 = (u2 * u) >> 30;
            w = (64'd1 << 30) - u;
            w2 = (w * w) >> 30;
            inner = 10 * (64'd1 << 30) + 6 * u2 - 15 * u;
            s = (u3 * inner) >> 30;
            dsdu = (30 * u2 * w2) >> 30;
            for (int i = 0; i < AXES; i++) begin
                d = goal_p[i] - start_p[i];
                mag = (d < 0) ? longint'(-d) : longint'(d);
                dp = scale_q30(mag, s);
                v = scale_q30(mag, dsdu);
                v = (v * 1000 + dur / 2) / dur;
                if (v > (64'd1 << 32))
                    v = 64'd1 << 32;
                ref_p[i] = (d < 0) ? start_p[i] - longint'(dp) : start_p[i] + longint'(dp);
                vs = (d < 0) ? -longint'(v) : longint'(v);
                if (vs > 64'sd2147483647)
                    vs = 64'sd2147483647;
                if (vs < -64'sd2147483648)
                    vs = -64'sd2147483648;
                ref_v[i] = vs;
            end
        endfunction

        function void write_limit(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
            if (idx >= 2 * AXES)
                return;
            if (idx[0])
                lim_hi[idx >> 1] = longint'($signed(data));
            else
                lim_lo[idx >> 1] = longint'($signed(data));
        endfunction

        // Advance the predictor by one accepted request and queue the output.
        function void note_request(traj_req_t r);
            traj_out_t exp_out;
            longint g;
            longint c;
            int unsigned t;
            if (r.req == REQ_START_ABS || r.req == REQ_START_REL) begin
                for (int i = 0; i < AXES; i++) begin
                    c = longint'($signed(r.cur[i]));
                    g = longint'($signed(r.tgt[i]));
                    if (r.req == REQ_START_REL)
                        g = g + c;
                    if (g < lim_lo[i]) g = lim_lo[i];
                    if (g > lim_hi[i]) g = lim_hi[i];
                    start_p[i] = c;
                    goal_p[i] = g;
                    ref_p[i] = c;
                    ref_v[i] = 0;
                end
                t = r.ms;
                if (t < MIN_MS) t = MIN_MS;
                if (t > MAX_MS) t = MAX_MS;
                dur = t;
                elapsed = 0;
                active = 1;
                done = 0;
                has_ref = 1;
            end else if (r.req == REQ_CLEAR) begin
                zero_motion();
            end else if (has_ref) begin
                if (!active) begin
                    hold_goal();
                end else begin
                    elapsed++;
                    if (elapsed >= dur) begin
                        hold_goal();
                        active = 0;
                        done = 1;
                    end else begin
                        eval_quintic();
                    end
                end
            end
            for (int i = 0; i < AXES; i++) begin
                exp_out.refp[i] = ref_p[i][POS_W-1:0];
                exp_out.vel[i] = ref_v[i][POS_W-1:0];
            end
            exp_out.has_ref = has_ref;
            exp_out.moving = active;
            exp_out.finished = done;
            pending_q.push_back(exp_out);
        endfunction

        function void check_result(traj_out_t act);
            traj_out_t exp_out;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, nothing pending", $time);
                errors++;
                return;
            end
            exp_out = pending_q.pop_front();
            checked++;
            for (int i = 0; i < AXES; i++) begin
                if (act.refp[i] !== exp_out.refp[i]) begin
                    $display("%0t: axis%0d ref expected %h actual %h",
                             $time, i + 1, exp_out.refp[i], act.refp[i]);
                    errors++;
                end
                if (act.vel[i] !== exp_out.vel[i]) begin
                    $display("%0t: axis%0d vel expected %h actual %h",
                             $time, i + 1, exp_out.vel[i], act.vel[i]);
                    errors++;
                end
            end
            if (act.has_ref !== exp_out.has_ref) begin
                $display("%0t: has_reference expected %b actual %b",
                         $time, exp_out.has_ref, act.has_ref);
                errors++;
            end
            if (act.moving !== exp_out.moving) begin
                $display("%0t: moving expected %b actual %b",
                         $time, exp_out.moving, act.moving);
                errors++;
            end
            if (act.finished !== exp_out.finished) begin
                $display("%0t: finished expected %b actual %b",
                         $time, exp_out.finished, act.finished);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0]     cfg_data = '0;
    logic                 s_valid = 0;
    logic                 s_ready;
    logic [1:0]           s_req_type = REQ_TICK;
    logic [POS_W-1:0]     s_tgt [AXES] = '{default: '0};
    logic [POS_W-1:0]     s_cur [AXES] = '{default: '0};
    logic [MS_W-1:0]      s_move_time_ms = '0;
    logic                 m_valid;
    logic                 m_ready = 0;
    logic [POS_W-1:0]     m_ref [AXES];
    logic [POS_W-1:0]     m_vel [AXES];
    logic                 m_has_reference;
    logic                 m_moving;
    logic                 m_finished;

    traj_scoreboard sb = new();
    bit quiet = 0;
    bit hold_off_req = 0;
    int hold_cnt = 0;
    int stall_cnt = 0;
    int watchdog = 0;
    int sent = 0;
    int starts = 0;
    int clears = 0;

    quintic_trajectory_generator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_axis1_target(s_tgt[0]), .s_axis2_target(s_tgt[1]),
        .s_axis3_target(s_tgt[2]),
        .s_axis1_current(s_cur[0]), .s_axis2_current(s_cur[1]),
        .s_axis3_current(s_cur[2]),
        .s_move_time_ms(s_move_time_ms),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_axis1_ref(m_ref[0]), .m_axis2_ref(m_ref[1]), .m_axis3_ref(m_ref[2]),
        .m_axis1_vel(m_vel[0]), .m_axis2_vel(m_vel[1]), .m_axis3_vel(m_vel[2]),
        .m_has_reference(m_has_reference), .m_moving(m_moving),
        .m_finished(m_finished)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // Result side: check accepted results, stall at random and hold off when asked.
    always @(posedge aclk) begin
        traj_out_t act;
        if (aresetn && m_valid && m_ready) begin
            for (int i = 0; i < AXES; i++) begin
                act.refp[i] = m_ref[i];
                act.vel[i] = m_vel[i];
            end
            act.has_ref = m_has_reference;
            act.moving = m_moving;
            act.finished = m_finished;
            sb.check_result(act);
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 0;
        end else if (hold_off_req) begin
            hold_off_req = 0;
            hold_cnt = HOLD_OFF_CYCLES;
            m_ready <= 0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_ready <= 0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(0, 9);
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            watchdog = 0;
        else
            watchdog++;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results pending", $time,
                     sb.pending_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one request and hold it until accepted; valid stays high afterwards.
    task automatic send_request(traj_req_t r);
        s_valid <= 1;
        s_req_type <= r.req;
        s_tgt <= r.tgt;
        s_cur <= r.cur;
        s_move_time_ms <= r.ms;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
        sent++;
        if (r.req == REQ_CLEAR) clears++;
        if (r.req == REQ_START_ABS || r.req == REQ_START_REL) starts++;
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_limit(idx, data);
    endtask

    // Lower valid and wait until every pending result has been checked.
    task automatic drain();
        s_valid <= 0;
        cfg_valid <= 0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
        endcase
    endfunction

    function automatic traj_req_t make_req(logic [1:0] code, logic [MS_W-1:0] ms);
        traj_req_t r;
        r.req = code;
        for (int i = 0; i < AXES; i++) begin
            r.tgt[i] = rand_pos();
            r.cur[i] = rand_pos();
        end
        r.ms = ms;
        return r;
    endfunction

    task automatic send_ticks(int n);
        repeat (n) begin
            send_request(make_req(REQ_TICK, MS_W'($urandom)));
            sender_gap();
        end
    endtask

    // One move: start, enough ticks to finish most of the time, then noise.
    task automatic random_move();
        traj_req_t r;
        int unsigned ms;
        ms = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 80);
        r = make_req($urandom_range(0, 1) ? REQ_START_ABS : REQ_START_REL, MS_W'(ms));
        send_request(r);
        sender_gap();
        send_ticks($urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(50, 85));
        if ($urandom_range(0, 4) == 0) begin
            send_request(make_req(REQ_CLEAR, MS_W'($urandom)));
            send_ticks($urandom_range(0, 2));
        end
    endtask

    task automatic random_limits();
        for (int k = 0; k < 2 * AXES; k++)
            write_reg(CFG_IDX_W'(k), rand_pos());
    endtask

    initial begin
        traj_req_t r;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: ticks before any reference, extremes, overflow, clamps.
        send_ticks(2);
        r = make_req(REQ_START_ABS, 16'd0);
        r.tgt = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        r.cur = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
        send_request(r);
        send_ticks(5);
        r = make_req(REQ_START_REL, 16'hFFFF);
        r.tgt = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
        r.cur = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        send_request(r);
        send_ticks(3);
        send_request(make_req(REQ_CLEAR, 16'd0));
        send_ticks(2);
        send_request(make_req(REQ_START_REL, 16'd49));
        send_ticks(3);
        send_request(make_req(REQ_START_ABS, 16'd60001));
        send_ticks(2);
        drain();

        // Tight limits, then inverted limits, then open extremes.
        for (int k = 0; k < AXES; k++) begin
            write_reg(CFG_IDX_W'(2 * k), 32'hFFF0_0000);
            write_reg(CFG_IDX_W'(2 * k + 1), 32'h0010_0000);
        end
        write_reg(3'd6, 32'h1234_5678);
        write_reg(3'd7, 32'hDEAD_BEEF);
        drain();
        repeat (4) random_move();
        drain();
        for (int k = 0; k < AXES; k++) begin
            write_reg(CFG_IDX_W'(2 * k), 32'h0100_0000);
            write_reg(CFG_IDX_W'(2 * k + 1), 32'hFF00_0000);
        end
        drain();
        repeat (2) random_move();

        // Receiver holds off while requests keep coming.
        hold_off_req = 1;
        send_ticks(10);
        drain();
        for (int k = 0; k < AXES; k++) begin
            write_reg(CFG_IDX_W'(2 * k), 32'h8000_0000);
            write_reg(CFG_IDX_W'(2 * k + 1), 32'h7FFF_FFFF);
        end
        drain();

        // Random part, with fresh limits now and then.
        while (sent < 600) begin
            random_move();
            if ($urandom_range(0, 5) == 0) begin
                drain();
                random_limits();
                drain();
            end
        end
        drain();
        write_reg(3'd0, 32'h8000_0000);
        write_reg(3'd1, 32'h7FFF_FFFF);
        drain();
        quiet = 1;
        while (sent < 700) random_move();
        drain();
        repeat (20) @(posedge aclk);

        $display("Sent %0d requests (%0d starts, %0d clears), checked %0d results.",
                 sent, starts, clears, sb.checked);
        $display("Limits covered reset, tight, inverted, out-of-range index and random.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
